FILE: rtl/core/ffha_pkg.sv
// Shared types, constants and codes for the first-fit heap allocator.
package ffha_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int HEADER_BYTES = 24;
  localparam int IDX_W        = $clog2(MAX_BLOCKS);
  localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
  localparam int OFF_W        = 16;
  localparam int BRK_W        = OFF_W + 1;

  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NULL    = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [OFF_W-1:0] start;
    logic [OFF_W-1:0] size;
    logic             free;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

endpackage

FILE: rtl/core/ffha_req_if.sv
// Request channel: valid/ready with action, size and offset.
interface ffha_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] request_bytes;
  logic [15:0] payload_offset;

  modport source (output valid, output action, output request_bytes,
                  output payload_offset, input ready);
  modport sink (input valid, input action, input request_bytes,
                input payload_offset, output ready);
endinterface

FILE: rtl/core/ffha_rsp_if.sv
// Result channel: valid/ready with status, granted offset and break flag.
interface ffha_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] granted_offset;
  logic        break_lowered;

  modport source (output valid, output status, output granted_offset,
                  output break_lowered, input ready);
  modport sink (input valid, input status, input granted_offset,
                input break_lowered, output ready);
endinterface

FILE: rtl/core/first_fit_heap_allocator.sv
// First-fit heap allocator top level: block table memory and sequencer.
// One request at a time. An allocate or release reads the block table one entry
// per cycle through the single read port of the table memory; a zero request or
// null offset skips the scan. A new request is taken while the previous result
// still waits in the output register. heap_limit (cfg_wdata) resets to 65535.
module first_fit_heap_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  ffha_req_if.sink    req,
  ffha_rsp_if.source  rsp
);

  ffha_pkg::mem_req_t mreq;
  ffha_pkg::entry_t   rdata;

  ffha_table_ram u_ram (
    .clk   (clk),
    .mreq  (mreq),
    .rdata (rdata)
  );

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp),
    .mreq      (mreq),
    .rdata     (rdata)
  );

endmodule

FILE: rtl/core/ffha_table_ram.sv
// Block table memory: one write port, one registered read port.
module ffha_table_ram (
  input  logic              clk,
  input  ffha_pkg::mem_req_t mreq,
  output ffha_pkg::entry_t   rdata
);

  ffha_pkg::entry_t mem [ffha_pkg::MAX_BLOCKS];

  always_ff @(posedge clk) begin
    if (mreq.we) begin
      mem[mreq.waddr] <= mreq.wdata;
    end
    if (mreq.re) begin
      rdata <= mem[mreq.raddr];
    end
  end

endmodule

FILE: rtl/core/ffha_ctrl.sv
// Allocator sequencer: table scan, update, break and result register.
module ffha_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  ffha_req_if.sink           req,
  ffha_rsp_if.source         rsp,
  output ffha_pkg::mem_req_t mreq,
  input  ffha_pkg::entry_t   rdata
);

  localparam int IW = ffha_pkg::IDX_W;
  localparam int CW = ffha_pkg::CNT_W;
  localparam int OW = ffha_pkg::OFF_W;
  localparam int BW = ffha_pkg::BRK_W;
  localparam logic [OW-1:0] HDR = OW'(ffha_pkg::HEADER_BYTES);
  localparam logic [CW-1:0] MAXC = CW'(ffha_pkg::MAX_BLOCKS);

  ffha_pkg::state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [BW-1:0] brk, brk_next;
  logic [OW-1:0] limit;
  logic [CW-1:0] iss_idx;
  logic          pend;
  logic [IW-1:0] pend_idx;
  logic          found;
  logic [IW-1:0] found_idx;
  logic [OW-1:0] found_start;
  logic [OW-1:0] found_size;
  logic          skip;
  logic          act;
  logic [OW-1:0] req_b;
  logic [OW-1:0] poff;
  logic          rsp_valid;
  logic [1:0]    rsp_status, status_next;
  logic [OW-1:0] rsp_grant, grant_next;
  logic          rsp_lowered, lowered_next;

  logic          accept;
  logic          hit;
  logic          scan_end;
  logic          out_free;
  logic          fin;
  logic [BW:0]   newbrk;

  assign accept   = req.valid && req.ready;
  assign req.ready = (state == ffha_pkg::S_IDLE);
  assign out_free = !rsp_valid || rsp.ready;
  assign fin      = (state == ffha_pkg::S_FIN) && out_free;
  assign newbrk   = (BW+1)'(brk) + (BW+1)'(HDR) + (BW+1)'(req_b);

  always_comb begin
    if (act == ffha_pkg::ACT_ALLOC) begin
      hit = pend && rdata.free && (req_b <= rdata.size);
    end else begin
      hit = pend && (({1'b0, rdata.start} + {1'b0, HDR}) == {1'b0, poff});
    end
  end

  assign scan_end = hit || (iss_idx >= count);

  always_comb begin
    // scan issues one read per cycle; compare runs in the cycle after each read
    mreq.re      = (state == ffha_pkg::S_SCAN) && !scan_end;
    mreq.raddr   = iss_idx[IW-1:0];
    status_next  = ffha_pkg::ST_OK;
    grant_next   = '0;
    lowered_next = 1'b0;
    count_next   = count;
    brk_next     = brk;
    mreq.we      = 1'b0;
    mreq.waddr   = found_idx;
    mreq.wdata   = '{start: found_start, size: found_size, free: 1'b0};
    if (skip) begin
      status_next = ffha_pkg::ST_NULL;
    end else if (act == ffha_pkg::ACT_ALLOC) begin
      if (found) begin
        mreq.we    = fin;
        grant_next = found_start + HDR;
      end else if (count >= MAXC || newbrk > (BW+1)'(limit)) begin
        status_next = ffha_pkg::ST_FULL;
      end else begin
        mreq.we    = fin;
        mreq.waddr = count[IW-1:0];
        mreq.wdata = '{start: brk[OW-1:0], size: req_b, free: 1'b0};
        grant_next = brk[OW-1:0] + HDR;
        count_next = count + CW'(1);
        brk_next   = newbrk[BW-1:0];
      end
    end else begin
      if (!found) begin
        status_next = ffha_pkg::ST_UNKNOWN;
      end else if ((CW'(found_idx) + CW'(1)) == count) begin
        lowered_next = 1'b1;
        count_next   = CW'(found_idx);
        brk_next     = BW'(found_start);
      end else begin
        mreq.we    = fin;
        mreq.wdata = '{start: found_start, size: found_size, free: 1'b1};
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ffha_pkg::S_IDLE: begin
        if (accept) begin
          if ((req.action == ffha_pkg::ACT_ALLOC) ? (req.request_bytes == '0)
                                                  : (req.payload_offset == '0)) begin
            state_next = ffha_pkg::S_FIN;
          end else begin
            state_next = ffha_pkg::S_SCAN;
          end
        end
      end
      ffha_pkg::S_SCAN: begin
        if (scan_end) begin
          state_next = ffha_pkg::S_FIN;
        end
      end
      ffha_pkg::S_FIN: begin
        if (out_free) begin
          state_next = ffha_pkg::S_IDLE;
        end
      end
      default: state_next = ffha_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ffha_pkg::S_IDLE;
      count     <= '0;
      brk       <= '0;
      limit     <= '1;
      rsp_valid <= 1'b0;
      pend      <= 1'b0;
      found     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        limit <= cfg_wdata;
      end
      if (fin) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      if (accept) begin
        pend  <= 1'b0;
        found <= 1'b0;
      end else if (state == ffha_pkg::S_SCAN) begin
        pend <= mreq.re;
        if (hit) begin
          found <= 1'b1;
        end
      end
      if (fin) begin
        count <= count_next;
        brk   <= brk_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act     <= req.action;
      req_b   <= req.request_bytes;
      poff    <= req.payload_offset;
      skip    <= (req.action == ffha_pkg::ACT_ALLOC) ? (req.request_bytes == '0)
                                                     : (req.payload_offset == '0);
      iss_idx <= '0;
    end else if (mreq.re) begin
      iss_idx  <= iss_idx + CW'(1);
      pend_idx <= iss_idx[IW-1:0];
    end
    if ((state == ffha_pkg::S_SCAN) && hit) begin
      found_idx   <= pend_idx;
      found_start <= rdata.start;
      found_size  <= rdata.size;
    end
    if (fin) begin
      rsp_status  <= status_next;
      rsp_grant   <= grant_next;
      rsp_lowered <= lowered_next;
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.status         = rsp_status;
  assign rsp.granted_offset = rsp_grant;
  assign rsp.break_lowered  = rsp_lowered;

`ifndef ASSERT_OFF
  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= MAXC)
    else $error("block count above table depth");
  a_brk_range: assert property (@(posedge clk) disable iff (rst) !brk[BW-1])
    else $error("break beyond offset range");
  a_write_fin: assert property (@(posedge clk) disable iff (rst)
    mreq.we |-> (state == ffha_pkg::S_FIN) && out_free)
    else $error("table write outside finish step");
  a_pend_idx: assert property (@(posedge clk) disable iff (rst)
    (state == ffha_pkg::S_SCAN) && pend |-> (CW'(pend_idx) < count))
    else $error("compare on entry beyond block count");
  a_fin_out: assert property (@(posedge clk) disable iff (rst)
    fin |=> rsp_valid && (state == ffha_pkg::S_IDLE))
    else $error("finish did not load result");
`endif

endmodule
